@@ hdl/assert_macros.svh @@
// Assertion macros shared by the LCD timing controller modules.
// With SYNTHESIS defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LCDT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("LCD timing invariant violated");

`define LCDT_ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("LCD timing property violated");

`else

`define LCDT_ASSERT_ALWAYS(label, clk, rst, cond)

`define LCDT_ASSERT_PROP(label, clk, rst, prop)

`endif

`endif

@@ hdl/lcdt_pkg.sv @@
`default_nettype none

package lcdt_pkg;

   localparam int CNT_W  = 10;
   localparam int LINE_W = 8;
   localparam int CYC_W  = 8;

   localparam int LCDT_LINE_DOTS = 456;
   localparam int OAM_DOTS       = 80;
   localparam int VRAM_DOTS      = 172;

   localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE   = 8'd153;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_VRAM   = 2'd3
   } lcdt_mode_type;

   typedef struct packed {
      logic [CYC_W-1:0]  elapsed_cycles;
      logic              lcd_enable;
      logic [LINE_W-1:0] line_compare;
      logic              hblank_irq_enable;
      logic              vblank_mode_irq_enable;
      logic              oam_irq_enable;
      logic              coincidence_irq_enable;
   } lcdt_req_type;

   typedef struct packed {
      logic [LINE_W-1:0] current_line;
      lcdt_mode_type     video_mode;
      logic              coincidence_flag;
      logic              stat_irq;
      logic              vblank_irq;
      logic              draw_line_request;
   } lcdt_rsp_type;

endpackage

`default_nettype wire

@@ hdl/lcdt_core.sv @@
`default_nettype none

`include "assert_macros.svh"

module lcdt_core
   import lcdt_pkg::*;
#(
   parameter int LINE_DOTS = LCDT_LINE_DOTS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire lcdt_req_type req,
   output lcdt_rsp_type      rsp
);

   localparam logic [CNT_W-1:0] RELOAD     = CNT_W'(LINE_DOTS);
   localparam logic [CNT_W-1:0] OAM_BOUND  = CNT_W'(LINE_DOTS - OAM_DOTS);
   localparam logic [CNT_W-1:0] VRAM_BOUND = CNT_W'(LINE_DOTS - OAM_DOTS - VRAM_DOTS);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LINE_W-1:0] line_ff, line_in;
   lcdt_mode_type     mode_ff, mode_in;
   logic              coin_ff, coin_in;

   logic [LINE_W-1:0] line_inc;
   logic [CNT_W-1:0]  cycles;
   lcdt_mode_type     mode_new;
   logic              mode_en;

   assign line_inc = line_ff + 8'd1;
   assign cycles   = {{(CNT_W-CYC_W){1'b0}}, req.elapsed_cycles};

   always_comb begin
      cnt_in   = cnt_ff;
      line_in  = line_ff;
      mode_in  = mode_ff;
      coin_in  = coin_ff;
      mode_new = MODE_HBLANK;
      mode_en  = 1'b0;
      rsp.stat_irq          = 1'b0;
      rsp.vblank_irq        = 1'b0;
      rsp.draw_line_request = 1'b0;

      if (!req.lcd_enable) begin
         cnt_in  = RELOAD;
         line_in = '0;
         mode_in = MODE_VBLANK;
      end else begin
         priority if (line_ff >= VBLANK_LINE) begin
            mode_new = MODE_VBLANK;
            mode_en  = req.vblank_mode_irq_enable;
         end else if (cnt_ff >= OAM_BOUND) begin
            mode_new = MODE_OAM;
            mode_en  = req.oam_irq_enable;
         end else if (cnt_ff >= VRAM_BOUND) begin
            mode_new = MODE_VRAM;
            mode_en  = 1'b0;
         end else begin
            mode_new = MODE_HBLANK;
            mode_en  = req.hblank_irq_enable;
         end
         mode_in = mode_new;
         coin_in = (line_ff == req.line_compare);
         rsp.stat_irq = (mode_en && (mode_new != mode_ff))
                        || (coin_in && req.coincidence_irq_enable);

         if (cnt_ff <= cycles) begin
            cnt_in = RELOAD;
            priority if (line_inc == VBLANK_LINE) begin
               line_in        = line_inc;
               rsp.vblank_irq = 1'b1;
            end else if (line_inc > LAST_LINE) begin
               line_in = '0;
            end else begin
               line_in               = line_inc;
               rsp.draw_line_request = (line_inc < VBLANK_LINE);
            end
         end else begin
            cnt_in = cnt_ff - cycles;
         end
      end

      rsp.current_line     = line_in;
      rsp.video_mode       = mode_in;
      rsp.coincidence_flag = coin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= RELOAD;
         line_ff <= '0;
         mode_ff <= MODE_HBLANK;
         coin_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff  <= cnt_in;
         line_ff <= line_in;
         mode_ff <= mode_in;
         coin_ff <= coin_in;
      end
   end

   `LCDT_ASSERT_PROP(a_disable_reload, clock, reset,
      (accept && !req.lcd_enable) |=> (line_ff == '0 && cnt_ff == RELOAD && mode_ff == MODE_VBLANK))
   `LCDT_ASSERT_PROP(a_vblank_line, clock, reset,
      (accept && rsp.vblank_irq) |=> (line_ff == VBLANK_LINE && cnt_ff == RELOAD))
   `LCDT_ASSERT_PROP(a_hold_idle, clock, reset,
      !accept |=> ($stable(line_ff) && $stable(cnt_ff) && $stable(mode_ff)))

endmodule

`default_nettype wire

@@ hdl/lcd_mode_timing_controller_unit.sv @@
// LCD mode timing controller: one result per accepted request.
// The result is registered in the main output register, or first in the skid register while the output stalls.
// Throughput: one request per cycle while the skid register is empty; a skid register keeps req_ready registered.
// Reset: the line countdown reloads to LINE_DOTS, line, mode and coincidence clear,
// and both output registers are emptied.
`default_nettype none

`include "assert_macros.svh"

module lcd_mode_timing_controller_unit
   import lcdt_pkg::*;
#(
   parameter int LINE_DOTS = LCDT_LINE_DOTS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CYC_W-1:0]  req_elapsed_cycles,
   input  wire logic              req_lcd_enable,
   input  wire logic [LINE_W-1:0] req_line_compare,
   input  wire logic              req_hblank_irq_enable,
   input  wire logic              req_vblank_mode_irq_enable,
   input  wire logic              req_oam_irq_enable,
   input  wire logic              req_coincidence_irq_enable,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [LINE_W-1:0]      rsp_current_line,
   output logic [1:0]             rsp_video_mode,
   output logic                   rsp_coincidence_flag,
   output logic                   rsp_stat_irq,
   output logic                   rsp_vblank_irq,
   output logic                   rsp_draw_line_request
);

   lcdt_req_type req;
   lcdt_rsp_type step_rsp;
   lcdt_rsp_type main_ff, skid_ff;
   logic         main_valid_ff, skid_valid_ff;
   logic         accept, drain;

   assign req.elapsed_cycles         = req_elapsed_cycles;
   assign req.lcd_enable             = req_lcd_enable;
   assign req.line_compare           = req_line_compare;
   assign req.hblank_irq_enable      = req_hblank_irq_enable;
   assign req.vblank_mode_irq_enable = req_vblank_mode_irq_enable;
   assign req.oam_irq_enable         = req_oam_irq_enable;
   assign req.coincidence_irq_enable = req_coincidence_irq_enable;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign drain     = !main_valid_ff || rsp_ready;

   lcdt_core #(
      .LINE_DOTS(LINE_DOTS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .rsp    (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         main_ff <= skid_valid_ff ? skid_ff : step_rsp;
      end else if (accept) begin
         skid_ff <= step_rsp;
      end
   end

   assign rsp_valid             = main_valid_ff;
   assign rsp_current_line      = main_ff.current_line;
   assign rsp_video_mode        = main_ff.video_mode;
   assign rsp_coincidence_flag  = main_ff.coincidence_flag;
   assign rsp_stat_irq          = main_ff.stat_irq;
   assign rsp_vblank_irq        = main_ff.vblank_irq;
   assign rsp_draw_line_request = main_ff.draw_line_request;

   `LCDT_ASSERT_ALWAYS(a_skid_behind_main, clock, reset, !skid_valid_ff || main_valid_ff)
   `LCDT_ASSERT_PROP(a_stall_fills_skid, clock, reset,
      (accept && !drain) |=> (skid_valid_ff && main_valid_ff))
   `LCDT_ASSERT_PROP(a_skid_moves_up, clock, reset,
      (skid_valid_ff && rsp_ready) |=> (main_valid_ff && !skid_valid_ff))

endmodule

`default_nettype wire

@@ tb/tb_lcd_mode_timing_controller_unit.sv @@
`default_nettype none

module tb_lcd_mode_timing_controller_unit
   import lcdt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_LIMIT   = 1000;

   class lcd_timing_tracker;
      logic [CNT_W-1:0]  dots;
      logic [LINE_W-1:0] line_now;
      lcdt_mode_type     mode_now;
      logic              coin_now;
      lcdt_rsp_type      expected_status[$];
      int                errors;

      function new();
         dots     = CNT_W'(LCDT_LINE_DOTS);
         line_now = '0;
         mode_now = MODE_HBLANK;
         coin_now = 1'b0;
         errors   = 0;
      endfunction

      function void note_request(lcdt_req_type r);
         int            cnt;
         lcdt_mode_type next_mode;
         logic          mode_irq_en;
         lcdt_rsp_type  e;
         e = '0;
         if (!r.lcd_enable) begin
            dots     = CNT_W'(LCDT_LINE_DOTS);
            line_now = '0;
            mode_now = MODE_VBLANK;
         end else begin
            cnt = int'(dots);
            if (line_now >= VBLANK_LINE) begin
               next_mode   = MODE_VBLANK;
               mode_irq_en = r.vblank_mode_irq_enable;
            end else if (cnt >= LCDT_LINE_DOTS - OAM_DOTS) begin
               next_mode   = MODE_OAM;
               mode_irq_en = r.oam_irq_enable;
            end else if (cnt >= LCDT_LINE_DOTS - OAM_DOTS - VRAM_DOTS) begin
               next_mode   = MODE_VRAM;
               mode_irq_en = 1'b0;
            end else begin
               next_mode   = MODE_HBLANK;
               mode_irq_en = r.hblank_irq_enable;
            end
            if (mode_irq_en && next_mode != mode_now) e.stat_irq = 1'b1;
            mode_now = next_mode;
            coin_now = (line_now == r.line_compare);
            if (coin_now && r.coincidence_irq_enable) e.stat_irq = 1'b1;
            cnt = cnt - int'(r.elapsed_cycles);
            if (cnt <= 0) begin
               // The overshoot past zero is dropped when the countdown reloads.
               line_now = line_now + 8'd1;
               cnt      = LCDT_LINE_DOTS;
               if (line_now == VBLANK_LINE) begin
                  e.vblank_irq = 1'b1;
               end else if (line_now > LAST_LINE) begin
                  line_now = '0;
               end else if (line_now < VBLANK_LINE) begin
                  e.draw_line_request = 1'b1;
               end
            end
            dots = cnt[CNT_W-1:0];
         end
         e.current_line     = line_now;
         e.video_mode       = mode_now;
         e.coincidence_flag = coin_now;
         expected_status.push_back(e);
      endfunction

      function void check_status(lcdt_rsp_type a);
         lcdt_rsp_type e;
         if (expected_status.size() == 0) begin
            $error("result transfer with no request pending: line %0d", a.current_line);
            errors++;
            return;
         end
         e = expected_status.pop_front();
         if (a.current_line !== e.current_line) begin
            $error("current_line: expected %0d, actual %0d", e.current_line, a.current_line);
            errors++;
         end
         if (a.video_mode !== e.video_mode) begin
            $error("video_mode: expected %0d, actual %0d", e.video_mode, a.video_mode);
            errors++;
         end
         if (a.coincidence_flag !== e.coincidence_flag) begin
            $error("coincidence_flag: expected %0b, actual %0b",
                   e.coincidence_flag, a.coincidence_flag);
            errors++;
         end
         if (a.stat_irq !== e.stat_irq) begin
            $error("stat_irq: expected %0b, actual %0b", e.stat_irq, a.stat_irq);
            errors++;
         end
         if (a.vblank_irq !== e.vblank_irq) begin
            $error("vblank_irq: expected %0b, actual %0b", e.vblank_irq, a.vblank_irq);
            errors++;
         end
         if (a.draw_line_request !== e.draw_line_request) begin
            $error("draw_line_request: expected %0b, actual %0b",
                   e.draw_line_request, a.draw_line_request);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CYC_W-1:0]  req_elapsed_cycles;
   logic              req_lcd_enable;
   logic [LINE_W-1:0] req_line_compare;
   logic              req_hblank_irq_enable;
   logic              req_vblank_mode_irq_enable;
   logic              req_oam_irq_enable;
   logic              req_coincidence_irq_enable;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [LINE_W-1:0] rsp_current_line;
   logic [1:0]        rsp_video_mode;
   logic              rsp_coincidence_flag;
   logic              rsp_stat_irq;
   logic              rsp_vblank_irq;
   logic              rsp_draw_line_request;

   lcd_timing_tracker tracker;
   int                idle_cycles;

   lcd_mode_timing_controller_unit DUT (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_elapsed_cycles         (req_elapsed_cycles),
      .req_lcd_enable             (req_lcd_enable),
      .req_line_compare           (req_line_compare),
      .req_hblank_irq_enable      (req_hblank_irq_enable),
      .req_vblank_mode_irq_enable (req_vblank_mode_irq_enable),
      .req_oam_irq_enable         (req_oam_irq_enable),
      .req_coincidence_irq_enable (req_coincidence_irq_enable),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_current_line           (rsp_current_line),
      .rsp_video_mode             (rsp_video_mode),
      .rsp_coincidence_flag       (rsp_coincidence_flag),
      .rsp_stat_irq               (rsp_stat_irq),
      .rsp_vblank_irq             (rsp_vblank_irq),
      .rsp_draw_line_request      (rsp_draw_line_request)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_item(input lcdt_req_type r);
      req_valid                  <= 1'b1;
      req_elapsed_cycles         <= r.elapsed_cycles;
      req_lcd_enable             <= r.lcd_enable;
      req_line_compare           <= r.line_compare;
      req_hblank_irq_enable      <= r.hblank_irq_enable;
      req_vblank_mode_irq_enable <= r.vblank_mode_irq_enable;
      req_oam_irq_enable         <= r.oam_irq_enable;
      req_coincidence_irq_enable <= r.coincidence_irq_enable;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(r);
   endtask

   initial begin
      int                sent;
      int                burst;
      int                gap;
      int                enabled_left;
      logic [CYC_W-1:0]  cyc;
      logic [LINE_W-1:0] cmp;
      logic [3:0]        irq_en;
      logic              en;
      tracker = new();
      reset                      <= 1'b1;
      req_valid                  <= 1'b0;
      req_elapsed_cycles         <= '0;
      req_lcd_enable             <= 1'b0;
      req_line_compare           <= '0;
      req_hblank_irq_enable      <= 1'b0;
      req_vblank_mode_irq_enable <= 1'b0;
      req_oam_irq_enable         <= 1'b0;
      req_coincidence_irq_enable <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Enable nibble order: hblank, vblank mode, oam, coincidence.
      send_item({8'd0,   1'b0, 8'd255, 4'b0000});
      send_item({8'd0,   1'b1, 8'd0,   4'b1111});
      send_item({8'd80,  1'b1, 8'd0,   4'b0010});
      send_item({8'd1,   1'b1, 8'd1,   4'b1110});
      send_item({8'd171, 1'b1, 8'd0,   4'b0001});
      send_item({8'd1,   1'b1, 8'd0,   4'b1111});
      send_item({8'd203, 1'b1, 8'd0,   4'b1000});
      send_item({8'd255, 1'b1, 8'd1,   4'b0101});
      send_item({8'd255, 1'b1, 8'd2,   4'b0000});
      send_item({8'd128, 1'b1, 8'd64,  4'b1111});
      send_item({8'd127, 1'b1, 8'd2,   4'b0001});
      send_item({8'd255, 1'b0, 8'd170, 4'b1111});
      send_item({8'd85,  1'b1, 8'd0,   4'b0011});
      send_item({8'd0,   1'b1, 8'd128, 4'b1111});
      send_item({8'd255, 1'b1, 8'd0,   4'b1111});

      // Long enabled stretches let the line count walk through whole frames,
      // with short disabled runs in between.
      sent         = 0;
      enabled_left = $urandom_range(200, 900);
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            if (enabled_left > 0) begin
               en = 1'b1;
               enabled_left--;
            end else begin
               en = 1'b0;
               if ($urandom_range(0, 1) == 0) enabled_left = $urandom_range(200, 900);
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: cyc = CYC_W'($urandom_range(128, 255));
               7:                   cyc = CYC_W'($urandom_range(0, 255));
               default:             cyc = CYC_W'($urandom_range(0, 8));
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2:             cmp = tracker.line_now;
               3, 4, 5, 6, 7:       cmp = LINE_W'($urandom_range(0, 153));
               default:             cmp = LINE_W'($urandom_range(0, 255));
            endcase
            irq_en = 4'($urandom_range(0, 15));
            send_item({cyc, en, cmp, irq_en});
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_status.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int run;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
         repeat (run) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
         run = $urandom_range(1, 8);
         repeat (run) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_status({rsp_current_line, rsp_video_mode, rsp_coincidence_flag,
                               rsp_stat_irq, rsp_vblank_irq, rsp_draw_line_request});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

`default_nettype wire
